[hw/rtl/zcpjd_pkg.sv]
package zcpjd_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned FRAME_W    = 10;
  localparam int unsigned PERIOD_W   = 10;
  localparam int unsigned FPB_W      = 7;
  localparam int unsigned PHASE_W    = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [FRAME_W-1:0]  FRAME_LENGTH_RST   = 10'd300;
  localparam logic [PERIOD_W-1:0] CARRIER_PERIOD_RST = 10'd96;
  localparam logic [FPB_W-1:0]    FRAMES_PER_BIT_RST = 7'd16;
  localparam logic [FPB_W-1:0]    FRAMES_PER_BIT_MAX = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_LENGTH   = 2'd0,
    REG_CARRIER_PERIOD = 2'd1,
    REG_FRAMES_PER_BIT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [FRAME_W-1:0]  frame_length;
    logic [PERIOD_W-1:0] carrier_period;
    logic [FPB_W-1:0]    frames_per_bit;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       resync;
  } item_t;

endpackage

[hw/rtl/zcpjd_cfg.sv]
module zcpjd_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [zcpjd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [zcpjd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output zcpjd_pkg::cfg_t                     cfg_o
);
  import zcpjd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_LENGTH:   cfg_d.frame_length   = cfg_data_i[FRAME_W-1:0];
        REG_CARRIER_PERIOD: cfg_d.carrier_period = cfg_data_i[PERIOD_W-1:0];
        REG_FRAMES_PER_BIT: cfg_d.frames_per_bit = cfg_data_i[FPB_W-1:0];
        default: ; // unmapped index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_length   <= FRAME_LENGTH_RST;
      cfg_q.carrier_period <= CARRIER_PERIOD_RST;
      cfg_q.frames_per_bit <= FRAMES_PER_BIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/zcpjd_in_stage.sv]
module zcpjd_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  zcpjd_pkg::item_t item_i,
  input  logic             advance_i,
  output logic             vld_o,
  output zcpjd_pkg::item_t item_o
);
  import zcpjd_pkg::*;

  logic  vld_q, vld_d;
  item_t item_q;
  logic  accept;

  // Take a new transaction whenever the stage is empty or the held one leaves this cycle.
  assign in_ready_o = !vld_q || advance_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (advance_i) begin
      vld_d = 1'b0;
    end
    if (accept) begin
      vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

[hw/rtl/zcpjd_core.sv]
module zcpjd_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  zcpjd_pkg::cfg_t  cfg_i,
  input  logic             vld_i,
  input  zcpjd_pkg::item_t item_i,
  output logic             advance_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             bit_res_o
);
  import zcpjd_pkg::*;

  logic signed [SAMPLE_W-1:0] prev_q, prev_d;
  logic [FRAME_W-1:0]         pos_q, pos_d;
  logic [FRAME_W-1:0]         rise_q, rise_d;
  logic [FRAME_W-1:0]         fall_q, fall_d;
  logic                       jump_q, jump_d;
  logic [PHASE_W-1:0]         phase_q, phase_d;
  logic                       out_vld_q, out_vld_d;
  logic                       out_bit_q;

  logic [FRAME_W-1:0]  len;
  logic [FPB_W-1:0]    fpb;
  logic [PHASE_W-1:0]  phase_cur;
  logic [FPB_W-1:0]    phase_inc;
  logic                cur_pos, cur_neg, prev_pos, prev_neg;
  logic                rise, fall;
  logic [FRAME_W-1:0]  last_sel;
  logic [FRAME_W-1:0]  gap;
  logic [PERIOD_W-1:0] half_period;
  logic                hit;
  logic                jump_after;
  logic                frame_end;
  logic                emit;
  logic                advance;

  always_comb begin
    len = (cfg_i.frame_length == '0) ? FRAME_W'(1) : cfg_i.frame_length;
    if (cfg_i.frames_per_bit == '0) begin
      fpb = FPB_W'(1);
    end else if (cfg_i.frames_per_bit > FRAMES_PER_BIT_MAX) begin
      fpb = FRAMES_PER_BIT_MAX;
    end else begin
      fpb = cfg_i.frames_per_bit;
    end

    phase_cur = item_i.resync ? '0 : phase_q;
    phase_inc = {1'b0, phase_cur} + FPB_W'(1);

    // Strict signs: zero is neither side.
    cur_neg  = item_i.sample[SAMPLE_W-1];
    cur_pos  = !cur_neg && (item_i.sample != '0);
    prev_neg = prev_q[SAMPLE_W-1];
    prev_pos = !prev_neg && (prev_q != '0);

    // The first sample of a frame is never paired with the one before it.
    rise = (pos_q != '0) && prev_neg && cur_pos;
    fall = (pos_q != '0) && prev_pos && cur_neg;

    last_sel    = rise ? rise_q : fall_q;
    gap         = pos_q - last_sel;
    half_period = cfg_i.carrier_period >> 1;
    hit         = (rise || fall) && (last_sel != '0) &&
                  (gap < cfg_i.carrier_period) && (gap > half_period);
    jump_after  = jump_q || hit;

    frame_end = ({1'b0, pos_q} + (FRAME_W+1)'(1)) >= {1'b0, len};
    emit      = frame_end && (phase_cur == '0);

    // Hold the transaction only if it has a result and the output is full and not being taken.
    advance = vld_i && (!emit || !out_vld_q || out_ready_i);

    prev_d  = prev_q;
    pos_d   = pos_q;
    rise_d  = rise_q;
    fall_d  = fall_q;
    jump_d  = jump_q;
    phase_d = phase_q;

    if (advance) begin
      prev_d = item_i.sample;
      if (frame_end) begin
        pos_d   = '0;
        rise_d  = '0;
        fall_d  = '0;
        jump_d  = emit ? 1'b0 : jump_after;
        phase_d = (phase_inc >= fpb) ? '0 : phase_inc[PHASE_W-1:0];
      end else begin
        pos_d   = pos_q + FRAME_W'(1);
        rise_d  = rise ? pos_q : rise_q;
        fall_d  = fall ? pos_q : fall_q;
        jump_d  = jump_after;
        phase_d = phase_cur;
      end
    end

    out_vld_d = (out_vld_q && !out_ready_i) || (advance && emit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      pos_q     <= '0;
      rise_q    <= '0;
      fall_q    <= '0;
      jump_q    <= 1'b0;
      phase_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      prev_q    <= prev_d;
      pos_q     <= pos_d;
      rise_q    <= rise_d;
      fall_q    <= fall_d;
      jump_q    <= jump_d;
      phase_q   <= phase_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_bit_q <= jump_after;
    end
  end

  assign advance_o   = advance;
  assign out_valid_o = out_vld_q;
  assign bit_res_o   = out_bit_q;

endmodule

[hw/rtl/zero_crossing_phase_jump_detector.sv]
// Zero-crossing phase-jump detector: signed 16-bit samples enter on a
// valid/ready channel and are grouped into frames of frame_length samples.
// Within a frame, rising and falling zero crossings (strict signs, the
// frame's first sample not paired with the previous frame) are tracked, and
// a gap between same-direction crossings strictly between carrier_period/2
// and carrier_period sets a sticky jump flag. The first frame after reset or
// a resync, and then every frames_per_bit-th frame, emits that flag as
// bit_res and clears it. One sample is taken per clock cycle unless the
// input stalls; a sample is held in the input register, and its result, if
// any, is registered on the output register as the sample leaves it.
// Input stalls only while a pending result is not taken and the held
// sample ends an emitting frame. Configuration writes (index 0 frame_length,
// 1 carrier_period, 2 frames_per_bit) take effect on the next cycle.
module zero_crossing_phase_jump_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [zcpjd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [zcpjd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [zcpjd_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                resync_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                bit_res_o
);
  import zcpjd_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  item_t held_item;
  logic  held_vld;
  logic  advance;

  assign in_item.sample = sample_i;
  assign in_item.resync = resync_i;

  zcpjd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  zcpjd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .vld_o      (held_vld),
    .item_o     (held_item)
  );

  zcpjd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .vld_i       (held_vld),
    .item_i      (held_item),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .bit_res_o   (bit_res_o)
  );

endmodule

[hw/rtl/zcpjd_checker.sv]
module zcpjd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic bit_res_o
);

  // Input backpressure only comes from a full, unaccepted output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");

  // A new result is only produced in a cycle where the input side moved.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_ready_o))
    else $error("result appeared while input stage was blocked");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("output transaction dropped before acceptance");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(bit_res_o))
    else $error("output payload changed while stalled");

endmodule

bind zero_crossing_phase_jump_detector zcpjd_checker u_zcpjd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .bit_res_o   (bit_res_o)
);
